// ----- src/assert_macros.svh -----
// Assertion macros used by the checker module of the Huffman bit packer.
// Depends on nothing; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define HCBP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hcbp: property violated");

// Check that a signal holds over the next edge once a condition is seen.
`define HCBP_ASSERT_HOLD(lbl, clk, rst_n, cond, sig) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error("hcbp: value did not hold");

`endif

// ----- src/hcbp_pkg.sv -----
// Shared types and constants of the Huffman code bit packer.
// Depends on nothing; every module of the block but hcbp_ram imports it.
package hcbp_pkg;

    // Field widths of the words on the ports
    localparam int MODE_W       = 2;
    localparam int SYM_FIELD_W  = 8;
    localparam int CODE_FIELD_W = 32;
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int VALID_W      = 4;

    // Defaults of the top-level parameters
    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_BITS_DEF  = 8;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Mode codes of an input word
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]       mode;
        logic [SYM_FIELD_W-1:0]  symbol;
        logic [CODE_FIELD_W-1:0] code_bits;
        logic [LEN_W-1:0]        code_length;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic [VALID_W-1:0] valid_bits;
        logic               last;
    } out_item_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic               nonempty;
        logic [Q_CNT_W-1:0] count;
    } q_stat_t;

endpackage

// ----- src/hcbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hcbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/hcbp_front.sv -----
// Front of the packer: accepts words, keeps the code table, classifies items.
// Depends on hcbp_pkg and hcbp_ram.
module hcbp_front #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_BITS  = hcbp_pkg::SYMBOL_BITS_DEF,
    parameter int CODE_W       = (MAX_CODE_LEN < hcbp_pkg::CODE_FIELD_W) ?
                                 MAX_CODE_LEN : hcbp_pkg::CODE_FIELD_W,
    parameter int QW           = 1 + hcbp_pkg::LEN_W + CODE_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hcbp_pkg::in_item_t in_word,
    output logic              full,
    input  hcbp_pkg::q_stat_t q_stat,
    output logic              q_push,
    output logic [QW-1:0]     q_data
);
    import hcbp_pkg::*;

    localparam int DEPTH   = 1 << SYMBOL_BITS;
    localparam int ADDR_W  = SYMBOL_BITS;
    localparam int ENTRY_W = LEN_W + CODE_W;
    localparam int SYM_EXT = (SYMBOL_BITS > SYM_FIELD_W) ? SYMBOL_BITS : SYM_FIELD_W;

    logic               clearing_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic               s1_valid_reg;
    logic               s1_flush_reg;

    logic               accept;
    logic [SYM_EXT-1:0] sym_ext;
    logic [ADDR_W-1:0]  addr;
    logic [LEN_W-1:0]   sat_len;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ENTRY_W-1:0] rdata;
    logic [Q_CNT_W:0]   in_flight;

    // Hold off input while clearing or while the queue has no credit left
    assign in_flight = {1'b0, q_stat.count} + (Q_CNT_W + 1)'(s1_valid_reg);
    assign full      = clearing_reg || (in_flight >= (Q_CNT_W + 1)'(Q_DEPTH));
    assign accept    = push && !full;

    // Mask the symbol to the table index
    assign sym_ext = SYM_EXT'(in_word.symbol);
    assign addr    = sym_ext[ADDR_W-1:0];

    // Saturate a loaded length at the longest storable code
    assign sat_len = (in_word.code_length > LEN_W'(CODE_W)) ? LEN_W'(CODE_W)
                                                            : in_word.code_length;

    // Table write: clearing pass first, then loads
    always_comb
    begin
        if (clearing_reg)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = accept && (in_word.mode == MODE_LOAD);
            waddr = addr;
            wdata = {sat_len, in_word.code_bits[CODE_W-1:0]};
        end
    end

    assign re = accept && (in_word.mode == MODE_ENCODE);

    hcbp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (addr),
        .rdata (rdata)
    );

    // Sweep the table after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == {ADDR_W{1'b1}})
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Advance encode and flush items alongside the table read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flush_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && ((in_word.mode == MODE_ENCODE) ||
                                       (in_word.mode == MODE_FLUSH));
            s1_flush_reg <= in_word.mode == MODE_FLUSH;
        end
    end

    assign q_push = s1_valid_reg;
    assign q_data = {s1_flush_reg, rdata};

endmodule

// ----- src/hcbp_queue.sv -----
// Short queue that decouples the front from the back of the packer.
// Depends on hcbp_pkg.
module hcbp_queue #(
    parameter int QW = 39
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_push,
    input  logic [QW-1:0]     q_data,
    input  logic              q_pop,
    output logic [QW-1:0]     q_head,
    output hcbp_pkg::q_stat_t q_stat
);
    import hcbp_pkg::*;

    logic [QW-1:0]      slots [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            slots[wr_ptr_reg] <= q_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_reg + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);
        end
    end

    assign q_head          = slots[rd_ptr_reg];
    assign q_stat.nonempty = count_reg != '0;
    assign q_stat.count    = count_reg;

endmodule

// ----- src/hcbp_back.sv -----
// Back of the packer: appends code bits to the accumulator and emits bytes.
// Depends on hcbp_pkg.
module hcbp_back #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int CODE_W       = (MAX_CODE_LEN < hcbp_pkg::CODE_FIELD_W) ?
                                 MAX_CODE_LEN : hcbp_pkg::CODE_FIELD_W,
    parameter int QW           = 1 + hcbp_pkg::LEN_W + CODE_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  hcbp_pkg::q_stat_t  q_stat,
    input  logic [QW-1:0]      q_head,
    output logic               q_pop,
    output logic               empty,
    input  logic               pop,
    output hcbp_pkg::out_item_t out_word
);
    import hcbp_pkg::*;

    localparam int ACC_W = (BYTE_W - 1) + CODE_W;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] acc_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic              head_flush;
    logic [LEN_W-1:0]  head_len;
    logic [CODE_W-1:0] head_code;
    logic [CODE_W-1:0] rev_code;
    logic [CODE_W-1:0] aligned;
    logic [ACC_W-1:0]  shifted;
    logic              slot_free;
    logic              has_byte;
    logic              emit_full;
    logic [CNT_W-1:0]  cnt_m8;
    logic [ACC_W-1:0]  rem_acc;
    logic [CNT_W-1:0]  rem_cnt;
    logic              take_enc;
    logic              take_flush;

    assign head_flush = q_head[QW-1];
    assign head_len   = q_head[QW-2:CODE_W];
    assign head_code  = q_head[CODE_W-1:0];

    // Reverse the code so its first bit lands lowest
    always_comb
    begin
        for (int i = 0; i < CODE_W; i++)
        begin
            rev_code[i] = head_code[CODE_W-1-i];
        end
    end

    assign aligned = rev_code >> (LEN_W'(CODE_W) - head_len);

    // Emit one full byte when the output slot can take it
    assign slot_free = !out_valid_reg || pop;
    assign has_byte  = cnt_reg >= CNT_W'(BYTE_W);
    assign emit_full = has_byte && slot_free;
    assign cnt_m8    = cnt_reg - CNT_W'(BYTE_W);
    assign rem_acc   = emit_full ? (acc_reg >> BYTE_W) : acc_reg;
    assign rem_cnt   = emit_full ? cnt_m8 : cnt_reg;

    // Take the next queued item once fewer than eight bits remain
    assign take_enc   = q_stat.nonempty && !head_flush && (rem_cnt < CNT_W'(BYTE_W));
    assign take_flush = q_stat.nonempty && head_flush && !has_byte && slot_free;
    assign q_pop      = take_enc || take_flush;

    assign shifted = ACC_W'(aligned) << rem_cnt[2:0];

    // Update the accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (take_flush)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (take_enc)
        begin
            acc_reg <= rem_acc | shifted;
            cnt_reg <= rem_cnt + CNT_W'(head_len);
        end
        else
        begin
            acc_reg <= rem_acc;
            cnt_reg <= rem_cnt;
        end
    end

    // Output register: drop on pop, load on emit or on a flush with bits left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_full || (take_flush && (cnt_reg != '0)))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_full)
        begin
            out_reg.out_byte   <= acc_reg[BYTE_W-1:0];
            out_reg.valid_bits <= VALID_W'(BYTE_W);
            out_reg.last       <= cnt_m8 < CNT_W'(BYTE_W);
        end
        else if (take_flush)
        begin
            out_reg.out_byte   <= acc_reg[BYTE_W-1:0];
            out_reg.valid_bits <= VALID_W'(cnt_reg);
            out_reg.last       <= 1'b1;
        end
    end

    assign empty    = !out_valid_reg;
    assign out_word = out_reg;

endmodule

// ----- src/huffman_code_bit_packer_top.sv -----
// Huffman code bit packer: table load, LSB-first code packing, flush.
// Throughput: one input word per cycle while full is low; one output byte per cycle
// while the receiver pops. A code longer than one byte holds the queue until fewer
// than eight bits remain in the accumulator. Reset: asynchronous, active low; then
// full stays high while the code table is swept to zero length.
module huffman_code_bit_packer_top #(
    parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_BITS  = hcbp_pkg::SYMBOL_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  hcbp_pkg::in_item_t  in_word,
    output logic                empty,
    input  logic                pop,
    output hcbp_pkg::out_item_t out_word
);
    import hcbp_pkg::*;

    localparam int CODE_W = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
    localparam int QW     = 1 + LEN_W + CODE_W;

    q_stat_t       q_stat;
    logic          q_push;
    logic [QW-1:0] q_data;
    logic          q_pop;
    logic [QW-1:0] q_head;

    hcbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_BITS  (SYMBOL_BITS),
        .CODE_W       (CODE_W),
        .QW           (QW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_word (in_word),
        .full    (full),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_data  (q_data)
    );

    hcbp_queue #(
        .QW (QW)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_data (q_data),
        .q_pop  (q_pop),
        .q_head (q_head),
        .q_stat (q_stat)
    );

    hcbp_back #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .CODE_W       (CODE_W),
        .QW           (QW)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .out_word (out_word)
    );

endmodule

// ----- src/hcbp_checker.sv -----
// Port-level checks on the Huffman code bit packer, bound to the top level.
// Depends on hcbp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hcbp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input hcbp_pkg::out_item_t out_word
);
    import hcbp_pkg::*;

    // A waiting byte holds until it is taken
    `HCBP_ASSERT_HOLD(a_out_hold, clk, rst_n, !empty && !pop, out_word)

    // Valid bit count is between one and eight
    `HCBP_ASSERT(a_valid_range, clk, rst_n, empty || ((out_word.valid_bits != '0) && (out_word.valid_bits <= VALID_W'(BYTE_W))))

    // A partial byte only comes from a flush, so it closes its item
    `HCBP_ASSERT(a_partial_last, clk, rst_n, empty || (out_word.valid_bits == VALID_W'(BYTE_W)) || out_word.last)

    // Unused high bits of a partial byte are zero
    `HCBP_ASSERT(a_partial_zero, clk, rst_n, empty || (out_word.valid_bits >= VALID_W'(BYTE_W)) || ((out_word.out_byte >> out_word.valid_bits) == '0))

endmodule

bind huffman_code_bit_packer_top hcbp_checker u_hcbp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
);
